>>> src/rlf_pkg.sv
// Shared types, codes and constants of the line-buffered receive FIFO.
`timescale 1ns / 1ps

package rlf_pkg;

    // Default ring size; one slot always stays free.
    localparam int unsigned DEPTH_DEF = 64;

    // Input operation codes.
    localparam logic [1:0] MODE_PUSH = 2'd0;
    localparam logic [1:0] MODE_LINE = 2'd1;
    localparam logic [1:0] MODE_CONN = 2'd2;

    // Result status codes.
    localparam logic [2:0] STAT_STORED   = 3'd0;
    localparam logic [2:0] STAT_DROPPED  = 3'd1;
    localparam logic [2:0] STAT_LINE     = 3'd2;
    localparam logic [2:0] STAT_NO_LINE  = 3'd3;
    localparam logic [2:0] STAT_REFUSED  = 3'd4;
    localparam logic [2:0] STAT_CONN_SET = 3'd5;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    // Cap on kept characters of one line (keeps a line read at no more than 64 results).
    localparam logic [5:0] LINE_CHAR_MAX = 6'd63;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
        logic [6:0] max_len;
        logic       link_up;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] line_char;
        logic       char_valid;
        logic       last;
    } out_item_t;

    // Result offered by the sequencer to the output stage.
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } emit_t;

endpackage

>>> src/line_buffered_receive_fifo_top.sv
// Top level of the line-buffered receive FIFO: sequencer, ring RAM, output stage.
`timescale 1ns / 1ps

// Line-buffered receive FIFO. Received bytes go into a ring of DEPTH bytes
// (at most DEPTH-1 held) and a read-line request pops up to and including
// the first newline, dropping carriage returns and characters beyond the
// length limit and returning each kept character as its own transfer, then
// a terminating transfer with last set. A running count of buffered newlines
// answers "no line" at once, so no scan is needed. Timing: a push, connection
// change, refused or no-line request runs in the cycle after its input
// transfer; its result is registered in the output register, and the input
// is ready again as that result appears there. A line read goes through a
// decode of the request, then for each popped byte a ring RAM read and a
// compare of that byte, then a return to idle to take the next item; every
// byte walks through the single RAM read port and its registered read data.
// A result that the result side holds off stalls the sequencer until it is
// taken. The input channel accepts one item at a time, but does take the
// next item while the last result of the previous one still waits in the
// output register. The ring RAM needs no clearing after reset; the block is
// ready straight after reset.
module line_buffered_receive_fifo_top import rlf_pkg::*; #(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int unsigned AW = $clog2(DEPTH);

    emit_t         emit;
    logic          emit_ready;
    logic          ram_we;
    logic [AW-1:0] ram_wr_addr;
    logic [7:0]    ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [7:0]    ram_rd_data;

    logic          m_valid_reg, m_valid_next;
    out_item_t     m_data_reg, m_data_next;

    // Sequencer: runs each item, walks the ring for line reads.
    rlf_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .emit        (emit),
        .emit_ready  (emit_ready),
        .ram_we      (ram_we),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    // Byte ring storage.
    rlf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Output register: take a new result when empty or being drained.
    assign emit_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (emit_ready) begin
            // Advance: load the offered result, or drop to empty.
            m_valid_next = emit.valid;
            if (emit.valid) begin
                m_data_next = emit.item;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> src/rlf_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module rlf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/rlf_ctrl.sv
// Sequencer of the receive FIFO: pointers, newline count, line walk.
`timescale 1ns / 1ps

module rlf_ctrl import rlf_pkg::*; #(
    parameter int unsigned DEPTH = DEPTH_DEF,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  in_item_t      s_data,
    output emit_t         emit,
    input  logic          emit_ready,
    output logic          ram_we,
    output logic [AW-1:0] ram_wr_addr,
    output logic [7:0]    ram_wr_data,
    output logic          ram_rd_en,
    output logic [AW-1:0] ram_rd_addr,
    input  logic [7:0]    ram_rd_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_FETCH = 2'd2;
    localparam logic [1:0] S_EVAL  = 2'd3;

    logic [1:0]    state_reg, state_next;
    in_item_t      item_reg, item_next;
    logic [AW-1:0] wr_pos_reg, wr_pos_next;
    logic [AW-1:0] rd_pos_reg, rd_pos_next;
    logic [AW-1:0] lf_cnt_reg, lf_cnt_next;
    logic          conn_reg, conn_next;
    logic [5:0]    k_reg, k_next;
    logic [5:0]    limit_reg, limit_next;
    logic [6:0]    len_m1;
    logic [AW-1:0] wr_pos_adv;
    logic [AW-1:0] rd_pos_adv;

    function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign wr_pos_adv  = adv(wr_pos_reg);
    assign rd_pos_adv  = adv(rd_pos_reg);
    assign len_m1      = item_reg.max_len - 7'd1;
    assign ram_wr_addr = wr_pos_reg;
    assign ram_wr_data = item_reg.rx_byte;
    assign ram_rd_addr = rd_pos_reg;

    always_comb begin
        state_next  = state_reg;
        item_next   = item_reg;
        wr_pos_next = wr_pos_reg;
        rd_pos_next = rd_pos_reg;
        lf_cnt_next = lf_cnt_reg;
        conn_next   = conn_reg;
        k_next      = k_reg;
        limit_next  = limit_reg;
        emit        = '0;
        ram_we      = 1'b0;
        ram_rd_en   = 1'b0;
        s_ready     = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                emit.valid     = 1'b1;
                emit.item.last = 1'b1;
                unique case (item_reg.mode)
                    MODE_PUSH: begin
                        if (!conn_reg || wr_pos_adv == rd_pos_reg) begin
                            emit.item.status = STAT_DROPPED;
                        end else begin
                            emit.item.status = STAT_STORED;
                            if (emit_ready) begin
                                ram_we      = 1'b1;
                                wr_pos_next = wr_pos_adv;
                                if (item_reg.rx_byte == CH_LF) begin
                                    lf_cnt_next = lf_cnt_reg + 1'b1;
                                end
                            end
                        end
                    end
                    MODE_LINE: begin
                        if (!conn_reg || item_reg.max_len == '0) begin
                            emit.item.status = STAT_REFUSED;
                        end else if (lf_cnt_reg == '0) begin
                            emit.item.status = STAT_NO_LINE;
                        end else begin
                            // A newline is buffered: start the walk, no result yet.
                            emit       = '0;
                            k_next     = '0;
                            limit_next = (len_m1 > {1'b0, LINE_CHAR_MAX}) ?
                                         LINE_CHAR_MAX : len_m1[5:0];
                            state_next = S_FETCH;
                        end
                    end
                    MODE_CONN: begin
                        emit.item.status = STAT_CONN_SET;
                        if (emit_ready) begin
                            conn_next = item_reg.link_up;
                            if (!item_reg.link_up) begin
                                wr_pos_next = '0;
                                rd_pos_next = '0;
                                lf_cnt_next = '0;
                            end
                        end
                    end
                    default: begin
                        emit.item.status = STAT_REFUSED;
                    end
                endcase
                if (emit.valid && emit_ready) begin
                    state_next = S_IDLE;
                end
            end
            S_FETCH: begin
                ram_rd_en  = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                priority if (ram_rd_data == CH_LF) begin
                    emit.valid       = 1'b1;
                    emit.item.status = STAT_LINE;
                    emit.item.last   = 1'b1;
                    if (emit_ready) begin
                        rd_pos_next = rd_pos_adv;
                        lf_cnt_next = lf_cnt_reg - 1'b1;
                        state_next  = S_IDLE;
                    end
                end else if (ram_rd_data == CH_CR || k_reg >= limit_reg) begin
                    rd_pos_next = rd_pos_adv;
                    state_next  = S_FETCH;
                end else begin
                    emit.valid           = 1'b1;
                    emit.item.status     = STAT_LINE;
                    emit.item.line_char  = ram_rd_data;
                    emit.item.char_valid = 1'b1;
                    if (emit_ready) begin
                        rd_pos_next = rd_pos_adv;
                        k_next      = k_reg + 1'b1;
                        state_next  = S_FETCH;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            wr_pos_reg <= '0;
            rd_pos_reg <= '0;
            lf_cnt_reg <= '0;
            conn_reg   <= 1'b1;
        end else begin
            state_reg  <= state_next;
            wr_pos_reg <= wr_pos_next;
            rd_pos_reg <= rd_pos_next;
            lf_cnt_reg <= lf_cnt_next;
            conn_reg   <= conn_next;
        end
        item_reg  <= item_next;
        k_reg     <= k_next;
        limit_reg <= limit_next;
    end

    // An empty ring holds no newline.
    a_empty_no_lf: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_pos_reg == wr_pos_reg) |-> (lf_cnt_reg == '0))
        else $error("newline count nonzero on empty ring");

    // The walk only runs while a newline is still ahead.
    a_fetch_has_lf: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FETCH) |-> (lf_cnt_reg != '0 && rd_pos_reg != wr_pos_reg))
        else $error("line walk without buffered newline");

    // A fetch is always followed by its evaluation.
    a_fetch_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FETCH) |=> (state_reg == S_EVAL))
        else $error("fetch not followed by evaluation");

    // Kept characters never exceed the line limit.
    a_char_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit.valid && emit.item.char_valid) |-> (k_reg < limit_reg))
        else $error("kept character beyond line limit");

endmodule
